### design/ppcv_pkg.sv
`timescale 1ns / 1ps
// Package for the point projection block: register codes, reset values,
// fixed widths of the mapping path and the saturating clip-sum helper. No dependencies.
package ppcv_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int COEFF_WIDTH_DEF = 16;
	localparam int COORD_FRAC      = 8;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 64;
	localparam int VP_W            = 12;
	localparam int SCREEN_W        = 16;
	localparam int DEPTH_W         = 15;
	localparam int DEPTH_FRAC      = 14;
	localparam int NORM_BITS       = 40;                    // |w| kept below 2^40
	localparam int SHIFT_W         = 5;
	localparam int DEN_W           = NORM_BITS + 1;         // 2*|w|
	localparam int SCALE_W         = 16;
	localparam int NUM_W           = DEN_W + SCALE_W + 1;
	localparam int QUO_W           = SCALE_W + 1;

	localparam logic [63:0] ROW0_RST = 64'h0000_0000_0000_1000;
	localparam logic [63:0] ROW1_RST = 64'h0000_0000_1000_0000;
	localparam logic [63:0] ROW2_RST = 64'h0000_1000_0000_0000;
	localparam logic [63:0] ROW3_RST = 64'h1000_0000_0000_0000;
	localparam logic [VP_W-1:0] WIDTH_RST  = 12'd640;
	localparam logic [VP_W-1:0] HEIGHT_RST = 12'd480;

	localparam logic [SCREEN_W-1:0] SCREEN_MAX = 16'hFFFF;
	localparam logic [DEPTH_W-1:0]  DEPTH_ONE  = 15'd16384;
	localparam logic [DEPTH_W-1:0]  DEPTH_MID  = 15'd8192;

	localparam logic signed [63:0] CLIP_LIMIT = 64'sh4000_0000_0000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW0   = 3'd0,
		REG_ROW1   = 3'd1,
		REG_ROW2   = 3'd2,
		REG_ROW3   = 3'd3,
		REG_WIDTH  = 3'd4,
		REG_HEIGHT = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic kept;
		logic zero_w;
		logic last;
	} side_t;

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(CLIP_LIMIT))
			return CLIP_LIMIT;
		else if (s < -65'(CLIP_LIMIT))
			return -CLIP_LIMIT;
		else
			return s[63:0];
	endfunction

endpackage

### design/ppcv_point_if.sv
`timescale 1ns / 1ps
// Input channel of the point projection block: one point a beat.
// Depends on ppcv_pkg.
interface ppcv_point_if import ppcv_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] point_z;
	logic                          last_point;

	modport source (output valid, point_x, point_y, point_z, last_point, input ready);
	modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

### design/ppcv_result_if.sv
`timescale 1ns / 1ps
// Result channel of the point projection block: one screen point a beat.
// Depends on ppcv_pkg.
interface ppcv_result_if import ppcv_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                inside_res;
	logic [SCREEN_W-1:0] screen_x;
	logic [SCREEN_W-1:0] screen_y;
	logic [DEPTH_W-1:0]  screen_z;
	logic                batch_end;

	modport source (output valid, inside_res, screen_x, screen_y, screen_z, batch_end,
		input ready);
	modport sink   (input valid, inside_res, screen_x, screen_y, screen_z, batch_end,
		output ready);
endinterface

### design/ppcv_cfg_if.sv
`timescale 1ns / 1ps
// Register write channel of the point projection block.
// Depends on ppcv_pkg.
interface ppcv_cfg_if import ppcv_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### design/point_project_clip_viewport.sv
`timescale 1ns / 1ps
// Top level of the point projection block. Uses ppcv_pkg, the three channel
// interfaces and ppcv_udiv_pipe.
//
// Projects one Q8.8 point a beat through a 4x4 Q4.12 matrix, divides by w, rejects points
// outside the unit cube and maps kept points to the viewport (Q12.4 x/y, Q1.14 depth).
// Throughput is one point per cycle while res.ready is high. Seven stages hold the matrix
// products, the three saturating sums, the inside test, the |w| normalization and the
// scale multiply, then seventeen divider stages (one quotient bit each), then the output
// register. Stages advance independently, so bubbles close up under back-pressure. The
// register channel is always ready; write it only while no point is in flight.
module point_project_clip_viewport import ppcv_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int COEFF_WIDTH = COEFF_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	ppcv_point_if.sink     pt,
	ppcv_result_if.source  res,
	ppcv_cfg_if.sink       cfg
);
	localparam int PW = COEFF_WIDTH + COORD_WIDTH;
	localparam int NS = 8 + QUO_W;

	// Registers
	logic [63:0]     row_q [4];
	logic [VP_W-1:0] width_q;
	logic [VP_W-1:0] height_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= ROW0_RST;
			row_q[1] <= ROW1_RST;
			row_q[2] <= ROW2_RST;
			row_q[3] <= ROW3_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_ROW0:   row_q[0] <= cfg.data;
				REG_ROW1:   row_q[1] <= cfg.data;
				REG_ROW2:   row_q[2] <= cfg.data;
				REG_ROW3:   row_q[3] <= cfg.data;
				REG_WIDTH:  width_q  <= cfg.data[VP_W-1:0];
				REG_HEIGHT: height_q <= cfg.data[VP_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage valid bits and enables
	logic [NS:1] vld_q;
	logic [NS:1] en;

	always_comb begin
		en[NS] = !vld_q[NS] || res.ready;
		for (int k = NS - 1; k >= 1; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	assign pt.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1])
				vld_q[1] <= pt.valid;
			for (int k = 2; k <= NS; k++)
				if (en[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	// Stage 1: coefficient products
	logic signed [COEFF_WIDTH-1:0] coef [4][4];
	logic signed [COORD_WIDTH-1:0] coord [3];
	logic signed [PW-1:0]          prod_s1 [4][4];
	logic                          last_s1;

	assign coord[0] = pt.point_x;
	assign coord[1] = pt.point_y;
	assign coord[2] = pt.point_z;

	for (genvar r = 0; r < 4; r++) begin : g_row
		logic [127:0] row_ext;
		assign row_ext = {64'b0, row_q[r]};
		for (genvar j = 0; j < 4; j++) begin : g_col
			// columns past bit 63 read as zero
			assign coef[r][j] = row_ext[j*COEFF_WIDTH +: COEFF_WIDTH];
			if (j < 3) begin : g_mul
				always_ff @(posedge clk)
					if (en[1])
						prod_s1[r][j] <= PW'(coef[r][j]) * PW'(coord[j]);
			end else begin : g_one
				always_ff @(posedge clk)
					if (en[1])
						prod_s1[r][j] <= PW'(coef[r][j]) <<< COORD_FRAC;
			end
		end
	end

	always_ff @(posedge clk)
		if (en[1])
			last_s1 <= pt.last_point;

	// Stages 2..4: saturating row sums, one add per stage
	logic signed [63:0] acc_s2 [4];
	logic signed [63:0] p2_s2  [4];
	logic signed [63:0] p3_s2  [4];
	logic signed [63:0] acc_s3 [4];
	logic signed [63:0] p3_s3  [4];
	logic signed [63:0] clip_s4 [4];
	logic               last_s2, last_s3, last_s4;

	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			if (en[2]) begin
				acc_s2[r] <= sat_add(64'(prod_s1[r][0]), 64'(prod_s1[r][1]));
				p2_s2[r]  <= 64'(prod_s1[r][2]);
				p3_s2[r]  <= 64'(prod_s1[r][3]);
			end
			if (en[3]) begin
				acc_s3[r] <= sat_add(acc_s2[r], p2_s2[r]);
				p3_s3[r]  <= p3_s2[r];
			end
			if (en[4])
				clip_s4[r] <= sat_add(acc_s3[r], p3_s3[r]);
		end
		if (en[2]) last_s2 <= last_s1;
		if (en[3]) last_s3 <= last_s2;
		if (en[4]) last_s4 <= last_s3;
	end

	// Stage 5: inside test and b = |w| + sign(w)*c
	logic [63:0] aw;
	logic [63:0] aw_s5;
	logic [63:0] b_s5 [3];
	side_t       side_s5;
	logic [2:0]  in_c;
	logic [63:0] b_c [3];

	assign aw = clip_s4[3][63] ? 64'(-clip_s4[3]) : clip_s4[3];

	always_comb begin
		logic signed [63:0] cs;
		logic [63:0]        ac;
		for (int i = 0; i < 3; i++) begin
			ac      = clip_s4[i][63] ? 64'(-clip_s4[i]) : clip_s4[i];
			in_c[i] = ac <= aw;
			cs      = clip_s4[3][63] ? -clip_s4[i] : clip_s4[i];
			b_c[i]  = aw + cs;
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			aw_s5          <= aw;
			b_s5           <= b_c;
			side_s5.kept   <= &in_c;
			side_s5.zero_w <= clip_s4[3] == '0;
			side_s5.last   <= last_s4;
		end
	end

	// Stage 6: shift |w| and b down together until |w| < 2^40
	logic [SHIFT_W-1:0]   shamt;
	logic [NORM_BITS-1:0] an_s6;
	logic [DEN_W-1:0]     bn_s6 [3];
	side_t                side_s6;

	always_comb begin
		shamt = '0;
		for (int i = NORM_BITS; i < 64; i++)
			if (aw_s5[i])
				shamt = SHIFT_W'(i - NORM_BITS + 1);
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			an_s6   <= NORM_BITS'(aw_s5 >> shamt);
			for (int i = 0; i < 3; i++)
				bn_s6[i] <= DEN_W'(b_s5[i] >> shamt);
			side_s6 <= side_s5;
		end
	end

	// Stage 7: numerator b*scale + |w|, denominator 2|w|
	logic [SCALE_W-1:0] scale [3];
	logic [NUM_W-1:0]   num_s7 [3];
	logic [DEN_W-1:0]   den_s7;
	side_t              side_s7;

	assign scale[0] = {width_q, 4'b0};
	assign scale[1] = {height_q, 4'b0};
	assign scale[2] = SCALE_W'(1) << DEPTH_FRAC;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			for (int i = 0; i < 3; i++)
				num_s7[i] <= NUM_W'(bn_s6[i]) * NUM_W'(scale[i]) + NUM_W'(an_s6);
			den_s7  <= {an_s6, 1'b0};
			side_s7 <= side_s6;
		end
	end

	// Stages 8..NS-1: one quotient bit per stage
	logic [QUO_W-1:0] quo [3];
	side_t            side_sd [QUO_W];

	for (genvar i = 0; i < 3; i++) begin : g_div
		ppcv_udiv_pipe #(
			.NW (NUM_W),
			.DW (DEN_W),
			.QW (QUO_W)
		) u_div (
			.clk (clk),
			.en  (en[NS-1:8]),
			.num (num_s7[i]),
			.den (den_s7),
			.quo (quo[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en[8])
			side_sd[0] <= side_s7;
		for (int i = 1; i < QUO_W; i++)
			if (en[8+i])
				side_sd[i] <= side_sd[i-1];
	end

	// Output stage: clamp, center for zero w, clear rejected points
	side_t               side_o;
	logic [SCREEN_W-1:0] sx_sat, sy_sat;
	logic [DEPTH_W-1:0]  sz_sat;
	logic                inside_so, last_so;
	logic [SCREEN_W-1:0] sx_so, sy_so;
	logic [DEPTH_W-1:0]  sz_so;

	assign side_o = side_sd[QUO_W-1];
	assign sx_sat = quo[0][QUO_W-1] ? SCREEN_MAX : quo[0][SCREEN_W-1:0];
	assign sy_sat = quo[1][QUO_W-1] ? SCREEN_MAX : quo[1][SCREEN_W-1:0];
	assign sz_sat = (quo[2] > QUO_W'(DEPTH_ONE)) ? DEPTH_ONE : quo[2][DEPTH_W-1:0];

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			last_so <= side_o.last;
			if (side_o.zero_w) begin
				inside_so <= 1'b1;
				sx_so     <= {1'b0, width_q, 3'b0};
				sy_so     <= {1'b0, height_q, 3'b0};
				sz_so     <= DEPTH_MID;
			end else if (side_o.kept) begin
				inside_so <= 1'b1;
				sx_so     <= sx_sat;
				sy_so     <= sy_sat;
				sz_so     <= sz_sat;
			end else begin
				inside_so <= 1'b0;
				sx_so     <= '0;
				sy_so     <= '0;
				sz_so     <= '0;
			end
		end
	end

	assign res.valid      = vld_q[NS];
	assign res.inside_res = inside_so;
	assign res.screen_x   = sx_so;
	assign res.screen_y   = sy_so;
	assign res.screen_z   = sz_so;
	assign res.batch_end  = last_so;

`ifndef SYNTHESIS
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.inside_res |->
			res.screen_x == '0 && res.screen_y == '0 && res.screen_z == '0)
		else $error("rejected point carries screen data");

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.screen_z <= DEPTH_ONE)
		else $error("depth above one");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		pt.valid && pt.ready |=> vld_q[1])
		else $error("accepted point lost at stage 1");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NS] && !res.ready |=> vld_q[NS] && $stable(sx_so) && $stable(sz_so))
		else $error("stalled result changed");
`endif
endmodule

### design/ppcv_udiv_pipe.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Quotient must fit QW bits. Stage enables come from the owner of the valid bits.
module ppcv_udiv_pipe #(
	parameter int NW = 58,
	parameter int DW = 41,
	parameter int QW = 17
) (
	input  logic          clk,
	input  logic [QW-1:0] en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);
	logic [NW-1:0] rem_sd [QW];
	logic [DW-1:0] den_sd [QW];
	logic [QW-1:0] quo_sd [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		localparam int BIT = QW - 1 - i;
		logic [NW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] quo_in;
		logic [NW-1:0] trial;
		if (i == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_sd[i-1];
			assign den_in = den_sd[i-1];
			assign quo_in = quo_sd[i-1];
		end
		assign trial = NW'(den_in) << BIT;
		always_ff @(posedge clk) begin
			if (en[i]) begin
				den_sd[i] <= den_in;
				if (rem_in >= trial) begin
					rem_sd[i]      <= rem_in - trial;
					quo_sd[i]      <= quo_in | (QW'(1) << BIT);
				end else begin
					rem_sd[i]      <= rem_in;
					quo_sd[i]      <= quo_in;
				end
			end
		end
	end

	assign quo = quo_sd[QW-1];
endmodule
